/* rtl/slbc_pkg.sv */
// Package for the status LED breathing controller: payload structs, register
// indexes, mode codes, sequencer states and the widths of the shared divider.
// No dependencies; every other file in rtl imports it.
package slbc_pkg;

  // Time base and field widths
  localparam int TIME_BITS = 32;
  localparam int LVL_W     = 8;
  localparam int Q16_W     = 16;
  localparam int CYC_W     = Q16_W + 2;             // sum of four 16-bit durations
  localparam int MUL_W     = CYC_W;                 // operand width of the multiplier
  localparam int PROD_W    = 2 * MUL_W;

  // Shared divider: dividend wide enough for time and the widest product,
  // rounded up to an even width as it retires two quotient bits a cycle.
  localparam int DIV_RAW   = (TIME_BITS > Q16_W + CYC_W) ? TIME_BITS : Q16_W + CYC_W;
  localparam int DIV_W     = ((DIV_RAW + 1) / 2) * 2;
  localparam int DIVR_W    = CYC_W;
  localparam int DIV_STEPS = 2;
  localparam int DIV_CYC   = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // Fixed-point constants
  localparam logic [Q16_W-1:0] Q16_ONE     = 16'hFFFF;
  localparam logic [CYC_W-1:0] Q16_THREE   = 18'd196605;
  localparam logic [31:0]      Q8_HALF     = 32'd32767;
  localparam logic [LVL_W:0]   DRIVEN_NONE = 9'h100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_LEVEL   = 3'd0,
    REG_SOLID_LEVEL = 3'd1,
    REG_BLINK_HALF  = 3'd2,
    REG_INHALE      = 3'd3,
    REG_PEAK        = 3'd4,
    REG_EXHALE      = 3'd5,
    REG_REST        = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_WAIT   = 2'd0,
    MODE_BREATH = 2'd1,
    MODE_STREAM = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [LVL_W-1:0] max_level;
    logic [LVL_W-1:0] solid_level;
    logic [Q16_W-1:0] blink_half_ms;
    logic [Q16_W-1:0] inhale_ms;
    logic [Q16_W-1:0] peak_ms;
    logic [Q16_W-1:0] exhale_ms;
    logic [Q16_W-1:0] rest_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic                 streaming;
    logic                 mounted;
  } in_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [1:0]       mode;
    logic             changed;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [DIVR_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ENTRY,
    S_BRANCH,
    S_PH_DIV,
    S_PH_WAIT,
    S_SEG,
    S_X_MUL,
    S_X_DIV,
    S_X_WAIT,
    S_SQ_MUL,
    S_SQ_DIV,
    S_SQ_WAIT,
    S_E_MUL,
    S_E_DIV,
    S_E_WAIT,
    S_SC_MUL,
    S_SC_DIV,
    S_SC_WAIT,
    S_DITHER,
    S_FIN
  } core_state_t;

endpackage

/* rtl/slbc_div.sv */
// Shared restoring divider of the LED controller, two quotient bits a cycle.
// Depends on slbc_pkg for widths and the request and response structs.
module slbc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  slbc_pkg::div_req_t req,
  output slbc_pkg::div_rsp_t rsp
);
  import slbc_pkg::*;

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIVR_W-1:0]    rem_r, rem_nxt;
  logic [DIVR_W-1:0]    dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIVR_W:0]      trial;

  // Two shift, compare and subtract steps per cycle.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial   = {rem_nxt, quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial      = trial - {1'b0, dsr_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DIVR_W-1:0];
    end
  end

  // Control: load on start, count down the steps, flag completion for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_CYC - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

  // A new division is never started while one is running.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("divider restarted while busy");

  // Completion follows the last step and only that.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("divider done without a run");

  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == '0 && !req.start |=> done_r) else $error("divider lost completion");

endmodule

/* rtl/slbc_core.sv */
// Sequencer and datapath of the LED controller: mode handling, blink timer,
// breathing curve through one shared multiplier and the shared divider, dither.
// Depends on slbc_pkg; drives slbc_div through a request struct.
module slbc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  slbc_pkg::cfg_t     cfg,
  input  logic               start,
  input  slbc_pkg::in_t      in_beat,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_take,
  output slbc_pkg::out_t     res,
  output slbc_pkg::div_req_t div_req,
  input  slbc_pkg::div_rsp_t div_rsp
);
  import slbc_pkg::*;

  core_state_t          state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  mode_t                mode_r, mode_nxt;
  mode_t                cur_mode_r, cur_mode_nxt;
  logic                 phase_r, phase_nxt;
  logic [TIME_BITS-1:0] last_tog_r, last_tog_nxt;
  logic [TIME_BITS-1:0] cyc_start_r, cyc_start_nxt;
  logic [LVL_W:0]       dither_r, dither_nxt;
  logic [LVL_W:0]       driven_r, driven_nxt;
  logic [CYC_W-1:0]     ph_r, ph_nxt;
  logic [Q16_W-1:0]     t_r, t_nxt;
  logic [Q16_W-1:0]     span_r, span_nxt;
  logic                 exh_r, exh_nxt;
  logic [Q16_W-1:0]     x_r, x_nxt;
  logic [Q16_W-1:0]     sq_r, sq_nxt;
  logic [Q16_W-1:0]     curve_r, curve_nxt;
  logic [PROD_W-1:0]    mul_r, mul_nxt;
  logic [Q16_W-1:0]     q8_r, q8_nxt;
  logic [LVL_W-1:0]     level_r, level_nxt;

  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [TIME_BITS-1:0] blink_el, breath_el;
  logic                 blink_due;
  logic [CYC_W-1:0]     e1, e2, e3, cyc;
  logic [31:0]          scaled;
  logic [LVL_W:0]       lvl9;
  logic [LVL_W+1:0]     dsum;
  logic [Q16_W-1:0]     e_val;

  // Elapsed times wrap with the time base.
  assign blink_el  = now_r - last_tog_r;
  assign breath_el = now_r - cyc_start_r;
  assign blink_due = blink_el >= TIME_BITS'(cfg.blink_half_ms);

  // Segment boundaries of the breathing cycle.
  assign e1  = CYC_W'(cfg.inhale_ms);
  assign e2  = e1 + CYC_W'(cfg.peak_ms);
  assign e3  = e2 + CYC_W'(cfg.exhale_ms);
  assign cyc = e3 + CYC_W'(cfg.rest_ms);

  // Curve times max_level, moved to Q8 and rounded before the final division.
  assign scaled = {mul_r[LVL_W+Q16_W-1:0], {LVL_W{1'b0}}} + Q8_HALF;
  assign e_val  = div_rsp.quot[Q16_W-1:0];

  // Dither: integer part plus a carry from the fraction accumulator, clamped.
  always_comb begin
    lvl9 = {1'b0, q8_r[Q16_W-1:LVL_W]};
    dsum = {1'b0, dither_r} + (LVL_W+2)'(q8_r[LVL_W-1:0]);
    if (dsum >= (LVL_W+2)'(DRIVEN_NONE)) begin
      lvl9 = lvl9 + 1'b1;
      dsum = dsum - (LVL_W+2)'(DRIVEN_NONE);
    end
    if (lvl9 > {1'b0, cfg.max_level}) begin
      lvl9 = {1'b0, cfg.max_level};
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (start) state_nxt = S_ENTRY;
      S_ENTRY:   state_nxt = S_BRANCH;
      S_BRANCH: begin
        if (mode_r == MODE_BREATH) begin
          state_nxt = (cyc == '0) ? S_SEG : S_PH_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PH_DIV:  state_nxt = S_PH_WAIT;
      S_PH_WAIT: if (div_rsp.done) state_nxt = S_SEG;
      S_SEG: begin
        if (ph_r < e1) begin
          state_nxt = S_X_MUL;
        end else if (ph_r < e2) begin
          state_nxt = S_SC_MUL;
        end else if (ph_r < e3) begin
          state_nxt = S_X_MUL;
        end else begin
          state_nxt = S_SC_MUL;
        end
      end
      S_X_MUL:   state_nxt = S_X_DIV;
      S_X_DIV:   state_nxt = S_X_WAIT;
      S_X_WAIT:  if (div_rsp.done) state_nxt = S_SQ_MUL;
      S_SQ_MUL:  state_nxt = S_SQ_DIV;
      S_SQ_DIV:  state_nxt = S_SQ_WAIT;
      S_SQ_WAIT: if (div_rsp.done) state_nxt = S_E_MUL;
      S_E_MUL:   state_nxt = S_E_DIV;
      S_E_DIV:   state_nxt = S_E_WAIT;
      S_E_WAIT:  if (div_rsp.done) state_nxt = S_SC_MUL;
      S_SC_MUL:  state_nxt = S_SC_DIV;
      S_SC_DIV:  state_nxt = S_SC_WAIT;
      S_SC_WAIT: if (div_rsp.done) state_nxt = S_DITHER;
      S_DITHER:  state_nxt = S_FIN;
      S_FIN:     if (res_take) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Outputs: handshake, multiplier operands and divider requests.
  always_comb begin
    idle            = (state_r == S_IDLE);
    res_valid       = (state_r == S_FIN);
    res.level       = level_r;
    res.mode        = mode_r;
    res.changed     = ({1'b0, level_r} != driven_r);
    mul_a           = '0;
    mul_b           = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      S_X_MUL: begin
        mul_a = MUL_W'(t_r);
        mul_b = MUL_W'(Q16_ONE);
      end
      S_SQ_MUL: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      S_E_MUL: begin
        mul_a = MUL_W'(sq_r);
        mul_b = Q16_THREE - MUL_W'({x_r, 1'b0});
      end
      S_SC_MUL: begin
        mul_a = MUL_W'(cfg.max_level);
        mul_b = MUL_W'(curve_r);
      end
      S_PH_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(breath_el);
        div_req.divisor  = cyc;
      end
      S_X_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_r[DIV_W-1:0];
        div_req.divisor  = DIVR_W'(span_r);
      end
      S_SQ_DIV, S_E_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_r[DIV_W-1:0];
        div_req.divisor  = DIVR_W'(Q16_ONE);
      end
      S_SC_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(scaled);
        div_req.divisor  = DIVR_W'(Q16_ONE);
      end
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    now_nxt       = now_r;
    mode_nxt      = mode_r;
    cur_mode_nxt  = cur_mode_r;
    phase_nxt     = phase_r;
    last_tog_nxt  = last_tog_r;
    cyc_start_nxt = cyc_start_r;
    dither_nxt    = dither_r;
    driven_nxt    = driven_r;
    ph_nxt        = ph_r;
    t_nxt         = t_r;
    span_nxt      = span_r;
    exh_nxt       = exh_r;
    x_nxt         = x_r;
    sq_nxt        = sq_r;
    curve_nxt     = curve_r;
    q8_nxt        = q8_r;
    level_nxt     = level_r;
    mul_nxt       = mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt = in_beat.now_ms;
          if (in_beat.streaming) begin
            mode_nxt = MODE_STREAM;
          end else if (in_beat.mounted) begin
            mode_nxt = MODE_BREATH;
          end else begin
            mode_nxt = MODE_WAIT;
          end
        end
      end
      // Entering a new mode restarts timers, dither and blink phase.
      S_ENTRY: begin
        if (mode_r != cur_mode_r) begin
          cur_mode_nxt  = mode_r;
          driven_nxt    = DRIVEN_NONE;
          phase_nxt     = 1'b1;
          dither_nxt    = '0;
          last_tog_nxt  = now_r;
          cyc_start_nxt = now_r;
        end
      end
      S_BRANCH: begin
        unique case (mode_r)
          MODE_STREAM: level_nxt = cfg.solid_level;
          MODE_WAIT: begin
            if (blink_due) begin
              phase_nxt    = ~phase_r;
              last_tog_nxt = now_r;
              level_nxt    = phase_r ? '0 : cfg.max_level;
            end else begin
              level_nxt    = phase_r ? cfg.max_level : '0;
            end
          end
          MODE_BREATH: if (cyc == '0) ph_nxt = '0;
          MODE_NONE: ;
        endcase
      end
      S_PH_WAIT: if (div_rsp.done) ph_nxt = div_rsp.rem;
      // Pick the segment of the breathing cycle.
      S_SEG: begin
        if (ph_r < e1) begin
          t_nxt    = ph_r[Q16_W-1:0];
          span_nxt = cfg.inhale_ms;
          exh_nxt  = 1'b0;
        end else if (ph_r < e2) begin
          curve_nxt = Q16_ONE;
        end else if (ph_r < e3) begin
          t_nxt    = Q16_W'(ph_r - e2);
          span_nxt = cfg.exhale_ms;
          exh_nxt  = 1'b1;
        end else begin
          curve_nxt = '0;
        end
      end
      S_X_WAIT:  if (div_rsp.done) x_nxt = e_val;
      S_SQ_WAIT: if (div_rsp.done) sq_nxt = e_val;
      S_E_WAIT: begin
        if (div_rsp.done) begin
          curve_nxt = exh_r ? (Q16_ONE - e_val) : e_val;
        end
      end
      S_SC_WAIT: if (div_rsp.done) q8_nxt = e_val;
      S_DITHER: begin
        level_nxt  = lvl9[LVL_W-1:0];
        dither_nxt = dsum[LVL_W:0];
      end
      S_FIN: if (res_take) driven_nxt = {1'b0, level_r};
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_mode_r  <= MODE_NONE;
      phase_r     <= 1'b1;
      last_tog_r  <= '0;
      cyc_start_r <= '0;
      dither_r    <= '0;
      driven_r    <= DRIVEN_NONE;
    end else begin
      state_r     <= state_nxt;
      cur_mode_r  <= cur_mode_nxt;
      phase_r     <= phase_nxt;
      last_tog_r  <= last_tog_nxt;
      cyc_start_r <= cyc_start_nxt;
      dither_r    <= dither_nxt;
      driven_r    <= driven_nxt;
    end
  end

  // Working registers of one beat.
  always_ff @(posedge clk) begin
    now_r   <= now_nxt;
    mode_r  <= mode_nxt;
    ph_r    <= ph_nxt;
    t_r     <= t_nxt;
    span_r  <= span_nxt;
    exh_r   <= exh_nxt;
    x_r     <= x_nxt;
    sq_r    <= sq_nxt;
    curve_r <= curve_nxt;
    mul_r   <= mul_nxt;
    q8_r    <= q8_nxt;
    level_r <= level_nxt;
  end

  // A result always carries a real mode, and it is the mode in force.
  a_mode_known: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> mode_r != MODE_NONE && mode_r == cur_mode_r)
    else $error("result without a current mode");

  // The breathing level never exceeds the configured maximum.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && mode_r == MODE_BREATH |-> level_r <= cfg.max_level)
    else $error("breathing level above maximum");

  // Divider completion only arrives while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_PH_WAIT || state_r == S_X_WAIT ||
                     state_r == S_SQ_WAIT || state_r == S_E_WAIT || state_r == S_SC_WAIT)
    else $error("divider result with nobody waiting");

  // A delivered level becomes the driven level.
  a_driven: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_take |=> driven_r == {1'b0, $past(level_r)})
    else $error("driven level not recorded");

endmodule

/* rtl/status_led_breathing_controller.sv */
// Top level of the status LED breathing controller: configuration registers,
// input and result handshakes with an output register. Depends on slbc_pkg,
// slbc_div and slbc_core.
//
//   Channel  Ports                          Beat
//   input    in_valid/in_ready/in_data      now_ms, streaming, mounted
//   result   out_valid/out_ready/out_data   level, mode, changed
//   config   cfg_we/cfg_addr/cfg_wdata      one register write per cycle
//
// Solid and blink beats pass the entry, branch and finish states on their way
// to the output register. Breathing beats on the hold or rest segments run up
// to two divisions and on the inhale or exhale segments five, all on the
// shared divider.
// Reset is synchronous, active low and restores the control and config registers.
// A result waiting in the output register does not block the next beat; the
// sequencer holds a finished result while the output register stays full.
module status_led_breathing_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  slbc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output slbc_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [slbc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [slbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import slbc_pkg::*;

  cfg_t     cfg_r;
  logic     core_idle;
  logic     res_valid;
  logic     out_free;
  out_t     res;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     out_valid_r;
  out_t     out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level     <= 8'd5;
      cfg_r.solid_level   <= 8'd1;
      cfg_r.blink_half_ms <= 16'd500;
      cfg_r.inhale_ms     <= 16'd1500;
      cfg_r.peak_ms       <= 16'd200;
      cfg_r.exhale_ms     <= 16'd2100;
      cfg_r.rest_ms       <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_LEVEL:   cfg_r.max_level     <= cfg_wdata[LVL_W-1:0];
        REG_SOLID_LEVEL: cfg_r.solid_level   <= cfg_wdata[LVL_W-1:0];
        REG_BLINK_HALF:  cfg_r.blink_half_ms <= cfg_wdata[Q16_W-1:0];
        REG_INHALE:      cfg_r.inhale_ms     <= cfg_wdata[Q16_W-1:0];
        REG_PEAK:        cfg_r.peak_ms       <= cfg_wdata[Q16_W-1:0];
        REG_EXHALE:      cfg_r.exhale_ms     <= cfg_wdata[Q16_W-1:0];
        REG_REST:        cfg_r.rest_ms       <= cfg_wdata[Q16_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake follows the sequencer.
  assign in_ready = core_idle;
  assign out_free = !out_valid_r || out_ready;

  slbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_valid && in_ready),
    .in_beat   (in_data),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_take  (out_free),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  slbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* bench/status_led_breathing_controller_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for status_led_breathing_controller: a scoreboard class predicts
// level, mode and the changed flag of each update beat, and plain tasks drive the block.
// Depends on slbc_pkg and the RTL of the block only.
module status_led_breathing_controller_test;
  import slbc_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  // Mirror of the controller: registers, mode state, blink and dither state.
  class led_scoreboard;
    cfg_t        regs;
    mode_t       cur_mode;
    bit          blink_on;
    logic [31:0] toggled_at;
    logic [31:0] cycle_origin;
    int unsigned dither_acc;
    int unsigned last_level;
    out_t        pending_levels[$];
    int          errors;

    function new();
      regs = '{max_level: 8'd5, solid_level: 8'd1, blink_half_ms: 16'd500,
               inhale_ms: 16'd1500, peak_ms: 16'd200, exhale_ms: 16'd2100,
               rest_ms: 16'd1000};
      cur_mode = MODE_NONE;
      blink_on = 1'b1;
      toggled_at = '0;
      cycle_origin = '0;
      dither_acc = 0;
      last_level = 256;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_MAX_LEVEL:   regs.max_level = v[7:0];
        REG_SOLID_LEVEL: regs.solid_level = v[7:0];
        REG_BLINK_HALF:  regs.blink_half_ms = v;
        REG_INHALE:      regs.inhale_ms = v;
        REG_PEAK:        regs.peak_ms = v;
        REG_EXHALE:      regs.exhale_ms = v;
        REG_REST:        regs.rest_ms = v;
        default: ;
      endcase
    endfunction

    // Smoothstep of t over span in Q16; a zero span gives zero.
    function longint unsigned smoothstep_q16(longint unsigned t, longint unsigned span);
      longint unsigned x;
      longint unsigned sq;
      if (span == 0) return 0;
      x = (t * 65535) / span;
      sq = (x * x) / 65535;
      return (sq * (3 * 65535 - 2 * x)) / 65535;
    endfunction

    // Breathing curve at phase ph, scaled to Q8 of the maximum level.
    function int unsigned breath_scaled(longint unsigned ph);
      longint unsigned curve;
      longint unsigned inhale_end;
      longint unsigned peak_end;
      longint unsigned exhale_end;
      longint unsigned scaled;
      inhale_end = regs.inhale_ms;
      peak_end = inhale_end + regs.peak_ms;
      exhale_end = peak_end + regs.exhale_ms;
      if (ph < inhale_end) begin
        curve = smoothstep_q16(ph, regs.inhale_ms);
      end else if (ph < peak_end) begin
        curve = 65535;
      end else if (ph < exhale_end) begin
        curve = smoothstep_q16(ph - peak_end, regs.exhale_ms);
        curve = (curve > 65535) ? 0 : 65535 - curve;
      end else begin
        curve = 0;
      end
      scaled = (longint'(regs.max_level) * 256 * curve + 32767) / 65535;
      return int'(scaled & 64'hffff);
    endfunction

    // Works out the result of one accepted update beat and queues it.
    function void note_update(in_t b);
      mode_t           mode;
      int unsigned     lvl;
      int unsigned     q8;
      longint unsigned span;
      longint unsigned ph;
      logic [31:0]     since;
      out_t            exp;
      mode = b.streaming ? MODE_STREAM : (b.mounted ? MODE_BREATH : MODE_WAIT);
      if (mode != cur_mode) begin
        cur_mode = mode;
        last_level = 256;
        blink_on = 1'b1;
        dither_acc = 0;
        toggled_at = b.now_ms;
        cycle_origin = b.now_ms;
      end
      if (mode == MODE_STREAM) begin
        lvl = regs.solid_level;
      end else if (mode == MODE_BREATH) begin
        span = longint'(regs.inhale_ms) + regs.peak_ms + regs.exhale_ms + regs.rest_ms;
        since = b.now_ms - cycle_origin;
        ph = (span == 0) ? 0 : longint'(since) % span;
        q8 = breath_scaled(ph);
        lvl = q8 >> 8;
        dither_acc += q8 & 8'hff;
        if (dither_acc >= 256) begin
          lvl++;
          dither_acc -= 256;
        end
        dither_acc &= 9'h1ff;
        if (lvl > regs.max_level) lvl = regs.max_level;
      end else begin
        since = b.now_ms - toggled_at;
        if (since >= regs.blink_half_ms) begin
          blink_on = !blink_on;
          toggled_at = b.now_ms;
        end
        lvl = blink_on ? regs.max_level : 0;
      end
      lvl &= 8'hff;
      exp.level = lvl[7:0];
      exp.mode = mode;
      exp.changed = (lvl != last_level);
      last_level = lvl;
      pending_levels.push_back(exp);
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function void check_level(out_t got);
      out_t exp;
      if (pending_levels.size() == 0) begin
        $display("%0t: result beat with nothing expected: level %0d mode %0d changed %0d",
                 $time, got.level, got.mode, got.changed);
        errors++;
        return;
      end
      exp = pending_levels.pop_front();
      if (got.level !== exp.level) begin
        $display("%0t: level expected %0d, got %0d", $time, exp.level, got.level);
        errors++;
      end
      if (got.mode !== exp.mode) begin
        $display("%0t: mode expected %0d, got %0d", $time, exp.mode, got.mode);
        errors++;
      end
      if (got.changed !== exp.changed) begin
        $display("%0t: changed expected %0d, got %0d", $time, exp.changed, got.changed);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  led_scoreboard sb = new();
  bit            quiet;
  bit            hold_req;
  logic [31:0]   clock_ms;
  int            idle_cycles;

  status_led_breathing_controller DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    clock_ms = '0;
  end

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t mk_update(logic [31:0] now, logic s, logic m);
    in_t b;
    b.now_ms = now;
    b.streaming = s;
    b.mounted = m;
    return b;
  endfunction

  // Offers one update beat, holds it until accepted, then idles at random.
  task automatic send_beat(input in_t b);
    int gap;
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_update(b);
    gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_MAX_LEVEL, {8'h00, c.max_level});
    write_reg(REG_SOLID_LEVEL, {8'h00, c.solid_level});
    write_reg(REG_BLINK_HALF, c.blink_half_ms);
    write_reg(REG_INHALE, c.inhale_ms);
    write_reg(REG_PEAK, c.peak_ms);
    write_reg(REG_EXHALE, c.exhale_ms);
    write_reg(REG_REST, c.rest_ms);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Reset settings: every mode, the segment edges of one breathing cycle
  // across the time wrap, blink toggles and both flags set together.
  task automatic directed_beats();
    logic [31:0] base;
    base = 32'hFFFF_FF00;
    send_beat(mk_update(32'd0, 1'b0, 1'b0));
    send_beat(mk_update(32'd499, 1'b0, 1'b0));
    send_beat(mk_update(32'd500, 1'b0, 1'b0));
    send_beat(mk_update(32'hFFFF_FFFF, 1'b0, 1'b0));
    send_beat(mk_update(32'd0, 1'b1, 1'b1));
    send_beat(mk_update(32'd10, 1'b1, 1'b0));
    send_beat(mk_update(32'hFFFF_FFFF, 1'b1, 1'b0));
    send_beat(mk_update(base, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd750, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd1499, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd1500, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd1600, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd1700, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd2750, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd3799, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd3800, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd4799, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd4800, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd4801, 1'b0, 1'b1));
    send_beat(mk_update(base + 32'd4900, 1'b0, 1'b0));
    in_valid <= 1'b0;
    wait_idle();
  endtask

  // Runs of one mode with time moving forward, mixed with stray beats.
  task automatic run_phase(input cfg_t c, input int n, input int step_max, input bit calm);
    int sent;
    int run_len;
    int k;
    int r;
    logic s;
    logic m;
    in_t b;
    apply_settings(c);
    quiet = calm;
    sent = 0;
    while (sent < n) begin
      run_len = $urandom_range(3, 40);
      r = $urandom_range(0, 99);
      s = (r >= 70);
      m = (r < 45) || (r >= 90);
      if ($urandom_range(0, 11) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 4);
      for (k = 0; k < run_len && sent < n; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          b = mk_update($urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          b = mk_update(clock_ms, s, m);
        end
        send_beat(b);
        sent++;
      end
    end
    in_valid <= 1'b0;
    wait_idle();
    quiet = 1'b0;
  endtask

  // Result side: checks each beat and stalls at random, once for a long stretch.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_level(out_data);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles in which no beat and no register write goes through.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status_led_breathing_controller_test failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin : stimulus
    cfg_t c;
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_beats();

    // Reset settings again, with the receiver holding off early on.
    hold_req = 1'b1;
    run_phase(sb.regs, 80, 400, 1'b0);

    c = '{max_level: 8'd255, solid_level: 8'd255, blink_half_ms: 16'd1,
          inhale_ms: 16'd1, peak_ms: 16'd0, exhale_ms: 16'd1, rest_ms: 16'd0};
    run_phase(c, 60, 3, 1'b0);

    c = '{max_level: 8'd255, solid_level: 8'd0, blink_half_ms: 16'hFFFF,
          inhale_ms: 16'hFFFF, peak_ms: 16'hFFFF, exhale_ms: 16'hFFFF, rest_ms: 16'hFFFF};
    run_phase(c, 60, 30000, 1'b0);

    // Skipped inhale and exhale, blink toggling on every beat, no idling.
    c = '{max_level: 8'd200, solid_level: 8'd128, blink_half_ms: 16'd0,
          inhale_ms: 16'd0, peak_ms: 16'd7, exhale_ms: 16'd0, rest_ms: 16'd9};
    run_phase(c, 60, 20, 1'b1);

    // Breathing cycle of zero length.
    c = '{max_level: 8'd255, solid_level: 8'd17, blink_half_ms: 16'd3,
          inhale_ms: 16'd0, peak_ms: 16'd0, exhale_ms: 16'd0, rest_ms: 16'd0};
    run_phase(c, 50, 5, 1'b0);

    c = '{max_level: 8'd0, solid_level: 8'd255, blink_half_ms: 16'd10,
          inhale_ms: 16'd40, peak_ms: 16'd0, exhale_ms: 16'd60, rest_ms: 16'd0};
    run_phase(c, 50, 15, 1'b0);

    for (i = 0; i < 2; i++) begin
      c.max_level = $urandom_range(0, 255);
      c.solid_level = $urandom_range(0, 255);
      c.blink_half_ms = $urandom_range(1, 200);
      c.inhale_ms = $urandom_range(1, 200);
      c.peak_ms = $urandom_range(0, 200);
      c.exhale_ms = $urandom_range(1, 200);
      c.rest_ms = $urandom_range(0, 200);
      run_phase(c, 60, 30, 1'b0);
    end

    c.max_level = $urandom_range(0, 255);
    c.solid_level = $urandom_range(0, 255);
    c.blink_half_ms = $urandom_range(0, 65535);
    c.inhale_ms = $urandom_range(0, 65535);
    c.peak_ms = $urandom_range(0, 65535);
    c.exhale_ms = $urandom_range(0, 65535);
    c.rest_ms = $urandom_range(0, 65535);
    run_phase(c, 60, $urandom_range(1, 40000), 1'b0);

    repeat (120) @(posedge clk);
    if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
      $display("status_led_breathing_controller_test passed");
    end else begin
      $display("status_led_breathing_controller_test failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/slbc_pkg.sv
rtl/slbc_div.sv
rtl/slbc_core.sv
rtl/status_led_breathing_controller.sv
bench/status_led_breathing_controller_test.sv
